// File: rtl/isst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isst_pkg;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } isst_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } isst_state_t;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned RES_W   = 16;

endpackage

`default_nettype wire

// File: rtl/integer_set_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Set of distinct signed 32-bit integers kept in a compact on-chip array.
// Each request on the s_ side adds, removes, looks up a value or clears
// the set. Each request gives exactly one result on the m_ side. An add of
// an absent value is refused with full_reject when CAPACITY entries are
// already held. The stored entries are scanned one per cycle through a
// single read port. Add and query scan the entries for the value. A remove
// scans up to the match, then shifts each later entry down by one place.
// Clear empties the set without a scan. A finished result waits in the
// output register while the next request is taken.

module integer_set_store
    import isst_pkg::*;
#(
    parameter int unsigned CAPACITY = 128
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                s_tvalid,
    output logic               s_tready,
    input  wire  [31:0]        s_tdata,   // value
    input  wire  [1:0]         s_tuser,   // kind
    output logic               m_tvalid,
    input  wire                m_tready,
    output logic [RES_W-1:0]   m_tdata    // success, full_reject, count[7:0], is_empty, zero pad
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = $clog2(CAPACITY);

    logic [VALUE_W-1:0] entries_mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;

    isst_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]      addr_reg, addr_next;
    isst_kind_t         kind_reg, kind_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               res_success_reg, res_success_next;
    logic               res_reject_reg, res_reject_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [RES_W-1:0]   m_tdata_reg, m_tdata_next;

    logic               rd_en;
    logic [AW-1:0]      raddr;
    logic               mem_we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;
    logic               more;
    logic               hit;
    logic [31:0]        cnt_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign more     = (addr_reg < count_reg);
    assign hit      = cmp_vld_reg && (rd_data_reg == value_reg);
    assign raddr    = addr_reg[AW-1:0];
    assign cnt_wide = 32'(count_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= entries_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg     <= cmp_idx_next;
        addr_reg        <= addr_next;
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        res_success_reg <= res_success_next;
        res_reject_reg  <= res_reject_next;
        m_tdata_reg     <= m_tdata_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        addr_next        = addr_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        res_success_next = res_success_reg;
        res_reject_next  = res_reject_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        waddr            = count_reg[AW-1:0];
        wdata            = value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next        = isst_kind_t'(s_tuser);
                    value_next       = s_tdata;
                    addr_next        = '0;
                    res_success_next = 1'b0;
                    res_reject_next  = 1'b0;
                    if (isst_kind_t'(s_tuser) == KIND_CLEAR)
                    begin
                        count_next       = '0;
                        res_success_next = 1'b1;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (more)
                begin
                    rd_en        = 1'b1;
                    addr_next    = addr_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = addr_reg;
                end
                if (hit)
                begin
                    cmp_vld_next = 1'b0;
                    case (kind_reg)
                        KIND_REMOVE:
                        begin
                            addr_next  = cmp_idx_reg + CW'(1);
                            state_next = ST_SHIFT;
                        end
                        KIND_QUERY:
                        begin
                            res_success_next = 1'b1;
                            state_next       = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else if (!cmp_vld_reg && !more)
                begin
                    // value absent
                    if (kind_reg == KIND_ADD)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            res_reject_next = 1'b1;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            count_next       = count_reg + CW'(1);
                            res_success_next = 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT:
            begin
                if (cmp_vld_reg)
                begin
                    mem_we = 1'b1;
                    waddr  = AW'(cmp_idx_reg - CW'(1));
                    wdata  = rd_data_reg;
                end
                if (more)
                begin
                    rd_en        = 1'b1;
                    addr_next    = addr_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = addr_reg;
                end
                else if (!cmp_vld_reg)
                begin
                    count_next       = count_reg - CW'(1);
                    res_success_next = 1'b1;
                    state_next       = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, (count_reg == '0), cnt_wide[COUNT_W-1:0],
                                     res_reject_reg, res_success_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_SCAN || state_reg == ST_SHIFT))
        else $error("array written outside scan or shift");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmp_vld_reg && state_reg == ST_SCAN) |-> (cmp_idx_reg < count_reg))
        else $error("compare index beyond stored entries");

    a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !(res_reject_reg && res_success_reg))
        else $error("reject and success both set");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("request accepted without starting work");

endmodule

`default_nettype wire
